// File: hdl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16LE transcoder.
package u8u16_pkg;

  // Input item function codes.
  localparam logic FuncData = 1'b0;
  localparam logic FuncEnd  = 1'b1;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QueueDepthDef = 2;

  // UTF-8 lead and continuation byte patterns.
  localparam logic [1:0] ContPrefix  = 2'b10;
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;
  localparam logic [4:0] Lead4Prefix = 5'b11110;

  // UTF-16 surrogate encoding constants.
  localparam logic [20:0] SuppBase   = 21'h010000;
  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;

  // One input item.
  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Work handed from the front to the back: one or two 16-bit units.
  typedef struct packed {
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } job_t;

endpackage

// File: hdl/utf8_to_utf16le_transcoder_top.sv
// Top level of the UTF-8 to UTF-16LE transcoder.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_ready_o  in_item_i  (func, in_byte)
//   output    out        out_valid_o/out_ready_i out_item_o (out_byte, last)
//
// The front decodes one item per cycle while the queue has room, and queues a job of
// one or two UTF-16 units. The back sends one byte per cycle while the receiver is
// ready, two bytes per unit; items that emit nothing queue no job.
// Reset clears the decoder state, the queue and the output valid flag, not the payload.
// A stalled output fills the queue, and then in_ready_o drops until it drains.
module utf8_to_utf16le_transcoder_top #(
  parameter int unsigned QueueDepth = u8u16_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u8u16_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8u16_pkg::out_item_t out_item_o
);

  logic            push;
  logic            push_ready;
  u8u16_pkg::job_t push_job;
  logic            pop;
  logic            pop_valid;
  u8u16_pkg::job_t pop_job;

  // Decoder.
  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (push_job)
  );

  // Job queue.
  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job)
  );

  // Byte serializer.
  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/u8u16_front.sv
// Front end: accepts UTF-8 items, tracks the pending sequence and builds UTF-16 units.
module u8u16_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  u8u16_pkg::in_item_t in_item_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output u8u16_pkg::job_t    job_o
);

  logic [20:0] partial_q, partial_d;
  logic [1:0]  pending_q, pending_d;
  logic        accept;
  logic        emit;
  logic [7:0]  c;
  logic [20:0] shifted;
  logic [20:0] supp;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign c          = in_item_i.in_byte;

  // Next code point with the continuation payload shifted in, and its supplementary offset.
  assign shifted = {partial_q[14:0], c[5:0]};
  assign supp    = shifted - u8u16_pkg::SuppBase;

  // Decode one item into the next state and an optional job.
  always_comb begin
    partial_d   = partial_q;
    pending_d   = pending_q;
    emit        = 1'b0;
    job_o.pair  = 1'b0;
    job_o.unit0 = '0;
    job_o.unit1 = '0;
    if (in_item_i.func == u8u16_pkg::FuncEnd) begin
      partial_d = '0;
      pending_d = '0;
      emit      = 1'b1;
    end else if (pending_q == 2'd0) begin
      if (c[7] == 1'b0) begin
        emit        = 1'b1;
        job_o.unit0 = {8'h00, c};
      end else if (c[7:5] == u8u16_pkg::Lead2Prefix) begin
        partial_d = {16'h0000, c[4:0]};
        pending_d = 2'd1;
      end else if (c[7:4] == u8u16_pkg::Lead3Prefix) begin
        partial_d = {17'h00000, c[3:0]};
        pending_d = 2'd2;
      end else if (c[7:3] == u8u16_pkg::Lead4Prefix) begin
        partial_d = {18'h00000, c[2:0]};
        pending_d = 2'd3;
      end
    end else if (c[7:6] != u8u16_pkg::ContPrefix) begin
      partial_d = '0;
      pending_d = '0;
    end else begin
      partial_d = shifted;
      pending_d = pending_q - 2'd1;
      if (pending_q == 2'd1) begin
        partial_d = '0;
        emit      = 1'b1;
        if (shifted[20:16] == 5'd0) begin
          job_o.unit0 = shifted[15:0];
        end else begin
          job_o.pair  = 1'b1;
          job_o.unit0 = u8u16_pkg::SurrHiBase + {5'd0, supp[20:10]};
          job_o.unit1 = u8u16_pkg::SurrLoBase | {6'd0, supp[9:0]};
        end
      end
    end
  end

  assign push_o = accept & emit;

  // Decoder state, updated only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pending_q <= '0;
    end else if (accept) begin
      partial_q <= partial_d;
      pending_q <= pending_d;
    end
  end

endmodule

// File: hdl/u8u16_queue.sv
// Small queue of UTF-16 jobs between the front and the back.
module u8u16_queue #(
  parameter int unsigned Depth = u8u16_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  u8u16_pkg::job_t push_job_i,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output u8u16_pkg::job_t pop_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u8u16_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: hdl/u8u16_back.sv
// Back end: splits queued UTF-16 units into little-endian bytes on the output channel.
module u8u16_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  u8u16_pkg::job_t      job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8u16_pkg::out_item_t out_item_o
);

  logic                 out_valid_q, out_valid_d;
  u8u16_pkg::out_item_t out_item_q, out_item_d;
  logic [1:0]           idx_q, idx_d;
  logic                 load;
  logic                 final_byte;
  logic [7:0]           sel_byte;

  // The output register takes a new byte when it is empty or being drained.
  assign load = job_valid_i & (~out_valid_q | out_ready_i);

  // Pick the byte of the head job, low byte of each unit first.
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = job_i.unit0[7:0];
      2'd1:    sel_byte = job_i.unit0[15:8];
      2'd2:    sel_byte = job_i.unit1[7:0];
      2'd3:    sel_byte = job_i.unit1[15:8];
      default: sel_byte = job_i.unit0[7:0];
    endcase
  end

  assign final_byte = job_i.pair ? (idx_q == 2'd3) : (idx_q == 2'd1);
  assign pop_o      = load & final_byte;

  // Next output register and byte index.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d         = 1'b1;
      out_item_d.out_byte = sel_byte;
      out_item_d.last     = final_byte;
      idx_d               = final_byte ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the UTF-8 to UTF-16LE transcoder top level.
module tb;
  import u8u16_pkg::*;

  // Tracks the decoder state and holds the UTF-16LE bytes still owed by the block.
  class utf16_scoreboard;
    out_item_t   owed_bytes[$];
    logic [20:0] code_acc;
    logic [1:0]  conts_left;
    int unsigned failures;
    int unsigned inputs_seen;
    int unsigned bytes_checked;
    int unsigned pairs_seen;
    int unsigned ends_seen;

    function new();
      code_acc      = '0;
      conts_left    = '0;
      failures      = 0;
      inputs_seen   = 0;
      bytes_checked = 0;
      pairs_seen    = 0;
      ends_seen     = 0;
    endfunction

    // Only the first ten failures are printed; the rest are just counted.
    function void count_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    // One 16-bit unit leaves the block low byte first.
    function void queue_unit(logic [15:0] unit, logic fin);
      out_item_t lo;
      out_item_t hi;
      lo.out_byte = unit[7:0];
      lo.last     = 1'b0;
      hi.out_byte = unit[15:8];
      hi.last     = fin;
      owed_bytes.insert(owed_bytes.size(), lo);
      owed_bytes.insert(owed_bytes.size(), hi);
    endfunction

    // Decodes one accepted input item and queues the bytes it produces.
    function void note_utf8_item(in_item_t it);
      logic [7:0]  c;
      logic [20:0] v;
      inputs_seen++;
      c = it.in_byte;
      if (it.func == FuncEnd) begin
        code_acc   = '0;
        conts_left = '0;
        ends_seen++;
        queue_unit(16'h0000, 1'b1);
        return;
      end
      // A start byte: ASCII goes straight out, a lead byte opens a sequence.
      if (conts_left == 2'd0) begin
        if (c[7] == 1'b0) begin
          queue_unit({8'h00, c}, 1'b1);
        end else if (c[7:5] == Lead2Prefix) begin
          code_acc   = {16'b0, c[4:0]};
          conts_left = 2'd1;
        end else if (c[7:4] == Lead3Prefix) begin
          code_acc   = {17'b0, c[3:0]};
          conts_left = 2'd2;
        end else if (c[7:3] == Lead4Prefix) begin
          code_acc   = {18'b0, c[2:0]};
          conts_left = 2'd3;
        end
        return;
      end
      // A byte that is not a continuation cancels the sequence.
      if (c[7:6] != ContPrefix) begin
        code_acc   = '0;
        conts_left = '0;
        return;
      end
      code_acc   = {code_acc[14:0], c[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left != 2'd0) begin
        return;
      end
      // Sequence complete: one unit, or a surrogate pair above the BMP.
      if (code_acc <= 21'h00FFFF) begin
        queue_unit(code_acc[15:0], 1'b1);
      end else begin
        v = code_acc - SuppBase;
        queue_unit(SurrHiBase + {5'b0, v[20:10]}, 1'b0);
        queue_unit(SurrLoBase + {6'b0, v[9:0]}, 1'b1);
        pairs_seen++;
      end
      code_acc = '0;
    endfunction

    // Compares one accepted output byte with the oldest owed byte.
    function void check_utf16_byte(out_item_t got);
      out_item_t want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        count_failure($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
        return;
      end
      want = owed_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.last !== want.last) begin
        count_failure($sformatf("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                want.out_byte, want.last, got.out_byte, got.last));
      end
    endfunction

    function int owed_count();
      return owed_bytes.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      in_ready_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  utf16_scoreboard sb = new();

  int send_idle_pct = 13;
  int recv_idle_pct = 55;
  int random_items  = 0;

  // Directed bytes: ASCII extremes, the 2-byte minimum, the 3-byte maximum, the 4-byte
  // minimum, a code point above the Unicode range, bad start bytes, a broken and an unfinished sequence.
  logic [7:0] dir_bytes [0:20] = '{
    8'h00, 8'h7F,
    8'hC2, 8'h80,
    8'hEF, 8'hBF, 8'hBF,
    8'hF0, 8'h90, 8'h80, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'h80, 8'hFF,
    8'hC3, 8'h41,
    8'hE2, 8'h82
  };

  utf8_to_utf16le_transcoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // The receiver stalls at random at the current rate.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_utf8_item(in_item_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_utf16_byte(out_item_o);
      end
    end
  end

  // Entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic f, logic [7:0] b, bit counted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_item_i.func    <= f;
    in_item_i.in_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (counted) begin
      random_items++;
    end
  endtask

  // Holds the input off until every owed byte has come out.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.owed_count() != 0);
  endtask

  function automatic logic [7:0] lead_byte(int len);
    case (len)
      2: begin
        return {Lead2Prefix, 5'($urandom)};
      end
      3: begin
        return {Lead3Prefix, 4'($urandom)};
      end
      default: begin
        return {Lead4Prefix, 3'($urandom)};
      end
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {ContPrefix, 6'($urandom)};
  endfunction

  // Mostly whole characters with random content, plus noise and broken sequences.
  task automatic send_random_char();
    int kind;
    int len;
    int keep;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_item(FuncData, {1'b0, 7'($urandom)}, 1'b1);
    end else if (kind < 75) begin
      len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
      send_item(FuncData, lead_byte(len), 1'b1);
      repeat (len - 1) send_item(FuncData, cont_byte(), 1'b1);
    end else if (kind < 82) begin
      send_item(FuncEnd, 8'($urandom), 1'b1);
    end else if (kind < 88) begin
      // Stray start byte; the block ignores it.
      b = $urandom_range(0, 1) ? {ContPrefix, 6'($urandom)} : {5'b11111, 3'($urandom)};
      send_item(FuncData, b, 1'b0);
    end else begin
      // A sequence cut short by a non-continuation byte or by end of string.
      len  = $urandom_range(2, 4);
      keep = $urandom_range(0, len - 2);
      send_item(FuncData, lead_byte(len), 1'b1);
      repeat (keep) send_item(FuncData, cont_byte(), 1'b1);
      if (kind < 96) begin
        do b = 8'($urandom); while (b[7:6] == ContPrefix);
        send_item(FuncData, b, 1'b1);
      end else begin
        send_item(FuncEnd, 8'($urandom), 1'b1);
      end
    end
  endtask

  task automatic random_phase(int budget);
    int stop;
    stop = random_items + budget;
    while (random_items < stop) begin
      send_random_char();
    end
  endtask

  // Main sequence: directed items, then four random phases under three stall settings.
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 55;
    foreach (dir_bytes[i]) begin
      send_item(FuncData, dir_bytes[i], 1'b0);
    end
    send_item(FuncEnd, 8'hFF, 1'b0);
    random_phase(27);
    wait_for_results();

    send_idle_pct = 55;
    recv_idle_pct = 13;
    random_phase(14);
    wait_for_results();
    random_phase(14);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(27);
    wait_for_results();
    repeat (16) @(negedge clk_i);

    if (sb.owed_count() != 0) begin
      sb.count_failure($sformatf("%0d bytes never arrived", sb.owed_count()));
    end
    $display("Sent %0d items, checked %0d output bytes: %0d surrogate pairs, %0d terminators.",
             sb.inputs_seen, sb.bytes_checked, sb.pairs_seen, sb.ends_seen);
    $display("Stalls covered: sender-light, receiver-light, none, with full drains between.");
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Run did not finish in time.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: utf8_to_utf16le_transcoder_top.f
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_queue.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16le_transcoder_top.sv
dv/tb.sv
